FILE: rtl/core/ibl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibl_pkg
// Shared types and fixed field widths of the interpolated blend lookup.
// ----------------------------------------------------------------------------
package ibl_pkg;

    // Fixed field widths
    localparam int SLOT_WIDTH  = 4;
    localparam int COUNT_WIDTH = 5;
    localparam int BLEND_WIDTH = 16;

    // Blend factor is Q1.15: shift out 15 bits, rounding by half an LSB
    localparam int BLEND_SHIFT = 15;
    localparam int ROUND_HALF  = 16384;

    // Operation codes of an input transaction
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    // Status of the shared divider
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage
`default_nettype wire

FILE: rtl/core/ibl_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibl_div
// Restoring divider, one quotient bit per cycle. Divides a 2*WIDTH-bit
// dividend by a WIDTH-bit divisor whose quotient is known to fit WIDTH bits.
// ----------------------------------------------------------------------------
module ibl_div #(
    parameter int WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [2*WIDTH-1:0]    i_dividend,
    input  logic [WIDTH-1:0]      i_divisor,
    output logic [WIDTH-1:0]      o_quotient,
    output ibl_pkg::t_div_stat    o_stat
);
    import ibl_pkg::*;

    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   trial_diff;
    logic             trial_ge;

    // One step: bring down the next dividend bit, subtract if it fits
    assign trial      = {r_rem, r_quo[WIDTH-1]};
    assign trial_diff = trial - {1'b0, i_divisor};
    assign trial_ge   = (trial >= {1'b0, i_divisor});

    // Sequencing; done pulses the cycle after the last step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[2*WIDTH-1:WIDTH];
            r_quo <= i_dividend[WIDTH-1:0];
        end else if (r_busy) begin
            r_rem <= trial_ge ? trial_diff[WIDTH-1:0] : trial[WIDTH-1:0];
            r_quo <= {r_quo[WIDTH-2:0], trial_ge};
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule
`default_nettype wire

FILE: rtl/core/interpolated_blend_lookup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// interpolated_blend_lookup
// Breakpoint table with linear interpolation of two curves and a final blend.
// ----------------------------------------------------------------------------
// A write transaction stores one breakpoint (key, alpha, omega) and returns
// nothing. A query walks the table one entry per cycle from slot 0. When the
// search stops on a key or outside the table, that entry's alpha and omega are
// blended as they are; otherwise alpha and omega are interpolated through one
// shared multiplier and one shared bit-serial divider, which runs once per
// curve, and the two are blended with the same multiplier.
// The input is not ready while a query is in progress; a finished result sits
// in the output register and the next transaction may be taken meanwhile.
// Table contents are undefined until written; entries_in_use must only be
// changed while the block is idle.
// ----------------------------------------------------------------------------
module interpolated_blend_lookup #(
    parameter int MAX_ENTRIES = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input transaction channel
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_operation,
    input  logic [ibl_pkg::SLOT_WIDTH-1:0]       i_entry_slot,
    input  logic signed [VALUE_WIDTH-1:0]        i_entry_key,
    input  logic signed [VALUE_WIDTH-1:0]        i_entry_alpha,
    input  logic signed [VALUE_WIDTH-1:0]        i_entry_omega,
    input  logic signed [VALUE_WIDTH-1:0]        i_query_level,
    input  logic [ibl_pkg::BLEND_WIDTH-1:0]      i_blend_factor,
    // Result channel
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [VALUE_WIDTH-1:0]        o_blended_value,
    output logic                                 o_saturated,
    // Configuration: entries_in_use
    input  logic                                 i_cfg_we,
    input  logic [ibl_pkg::COUNT_WIDTH-1:0]      i_cfg_wdata
);
    import ibl_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int XW = (AW > SLOT_WIDTH) ? AW : SLOT_WIDTH;
    localparam int EW = 3 * VW;
    localparam int MA = VW + 1;
    localparam int MB = (VW + 1 > BLEND_WIDTH + 1) ? VW + 1 : BLEND_WIDTH + 1;
    localparam int PW = MA + MB;
    localparam int TW = PW - BLEND_SHIFT;
    localparam int RW = TW + 1;

    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SEARCH = 7'b0000010,
        S_LDIFF  = 7'b0000100,
        S_BDIFF  = 7'b0001000,
        S_MUL    = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_SAT    = 7'b1000000
    } t_state;

    t_state                   r_state;
    logic [COUNT_WIDTH-1:0]   r_entries_in_use;

    logic [EW-1:0]            mem [MAX_ENTRIES];
    logic [EW-1:0]            r_rd;
    logic [AW-1:0]            r_addr;
    logic [AW-1:0]            r_rd_idx;
    logic                     r_rd_vld;
    logic [AW-1:0]            r_last;

    logic signed [VW-1:0]     r_level;
    logic [BLEND_WIDTH-1:0]   r_blend;
    logic signed [VW-1:0]     r_prev_key;
    logic signed [VW-1:0]     r_prev_alpha;
    logic signed [VW-1:0]     r_prev_omega;
    logic [VW-1:0]            r_dl;
    logic [VW-1:0]            r_dd;
    logic                     r_sel;
    logic                     r_blend_phase;
    logic signed [VW-1:0]     r_v0;
    logic                     r_neg;
    logic signed [MA-1:0]     r_mul_a;
    logic signed [MB-1:0]     r_mul_b;
    logic signed [PW-1:0]     r_prod;
    logic                     r_div_go;
    logic signed [VW-1:0]     r_a;
    logic signed [VW-1:0]     r_o;
    logic                     r_out_valid;
    logic signed [VW-1:0]     r_out_value;
    logic                     r_out_sat;

    logic                     in_acc;
    logic [XW-1:0]            slot_x;
    logic                     wr_en;
    logic                     rd_en;
    logic [AW-1:0]            last_n;
    logic signed [VW-1:0]     rd_key;
    logic signed [VW-1:0]     rd_alpha;
    logic signed [VW-1:0]     rd_omega;
    logic                     hit;
    logic                     exact;
    logic                     stop;
    logic                     interp;
    logic [VW:0]              dl_w;
    logic [VW:0]              dd_w;
    logic signed [VW-1:0]     v0;
    logic signed [VW-1:0]     v1;
    logic [VW:0]              dv;
    logic [VW:0]              dv_abs;
    logic [VW:0]              bdiff;
    logic [VW-1:0]            quo;
    logic [VW-1:0]            lerp_val;
    t_div_stat                div_stat;
    logic signed [PW-1:0]     rnd;
    logic signed [TW-1:0]     term;
    logic signed [RW-1:0]     res;
    logic                     sat_hi;
    logic                     sat_lo;
    logic                     out_load;

    // Handshake
    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign o_valid = r_out_valid;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= COUNT_WIDTH'(1);
        end else if (i_cfg_we) begin
            r_entries_in_use <= i_cfg_wdata;
        end
    end

    // Last slot searched: zero acts as one, anything past the table as full
    always_comb begin
        if (r_entries_in_use == '0) begin
            last_n = '0;
        end else if (32'(r_entries_in_use) > 32'(MAX_ENTRIES)) begin
            last_n = AW'(MAX_ENTRIES - 1);
        end else begin
            last_n = AW'(r_entries_in_use - 1'b1);
        end
    end

    // Breakpoint memory: written on a write transaction, read during the walk
    assign slot_x = XW'(i_entry_slot);
    assign wr_en  = in_acc && (i_operation == OP_WRITE)
                    && ({1'b0, slot_x} < (XW + 1)'(MAX_ENTRIES));
    assign rd_en  = (r_state == S_SEARCH) && !stop;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[slot_x[AW-1:0]] <= {i_entry_key, i_entry_alpha, i_entry_omega};
        end
        if (rd_en) begin
            r_rd     <= mem[r_addr];
            r_rd_idx <= r_addr;
        end
    end

    assign rd_key   = r_rd[EW-1 -: VW];
    assign rd_alpha = r_rd[2*VW-1 -: VW];
    assign rd_omega = r_rd[VW-1:0];

    // Search compare on the entry just read
    assign hit    = (r_level <= rd_key);
    assign exact  = (r_level == rd_key);
    assign stop   = (r_state == S_SEARCH) && r_rd_vld && (hit || (r_rd_idx == r_last));
    assign interp = hit && !((r_rd_idx == '0) || exact);

    assign dl_w = {r_level[VW-1], r_level} - {r_prev_key[VW-1], r_prev_key};
    assign dd_w = {rd_key[VW-1], rd_key} - {r_prev_key[VW-1], r_prev_key};

    // Curve difference for the interpolation of alpha, then omega
    assign v0     = r_sel ? r_prev_omega : r_prev_alpha;
    assign v1     = r_sel ? rd_omega : rd_alpha;
    assign dv     = {v1[VW-1], v1} - {v0[VW-1], v0};
    assign dv_abs = dv[VW] ? (~dv + 1'b1) : dv;

    // Difference for the blend
    assign bdiff = {r_a[VW-1], r_a} - {r_o[VW-1], r_o};

    // Shared divider
    ibl_div #(
        .WIDTH      (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_prod[2*VW-1:0]),
        .i_divisor  (r_dd),
        .o_quotient (quo),
        .o_stat     (div_stat)
    );

    assign lerp_val = r_neg ? (r_v0 - quo) : (r_v0 + quo);

    // Rounding, blend sum and saturation
    assign rnd      = r_prod + signed'(PW'(ROUND_HALF));
    assign term     = rnd[PW-1:BLEND_SHIFT];
    assign res      = RW'(term) + RW'(r_o);
    assign sat_hi   = (res > RW'(VMAX));
    assign sat_lo   = (res < RW'(VMIN));
    assign out_load = (r_state == S_SAT) && (!r_out_valid || i_ready);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_div_go    <= 1'b0;
        end else begin
            // divider kicks off as the interpolation product lands
            r_div_go <= (r_state == S_MUL) && !r_blend_phase;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_operation == OP_QUERY)) begin
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (stop) begin
                        r_state <= interp ? S_LDIFF : S_BDIFF;
                    end
                end
                S_LDIFF: begin
                    r_state <= S_MUL;
                end
                S_BDIFF: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_blend_phase) begin
                        r_state <= S_SAT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_state <= r_sel ? S_BDIFF : S_LDIFF;
                    end
                end
                S_SAT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_level  <= i_query_level;
                    r_blend  <= i_blend_factor;
                    r_last   <= last_n;
                    r_addr   <= '0;
                    r_rd_vld <= 1'b0;
                end
            end
            S_SEARCH: begin
                r_addr   <= r_addr + 1'b1;
                r_rd_vld <= 1'b1;
                if (r_rd_vld) begin
                    if (stop) begin
                        if (interp) begin
                            r_dl  <= dl_w[VW-1:0];
                            r_dd  <= dd_w[VW-1:0];
                            r_sel <= 1'b0;
                        end else begin
                            r_a <= rd_alpha;
                            r_o <= rd_omega;
                        end
                    end else begin
                        r_prev_key   <= rd_key;
                        r_prev_alpha <= rd_alpha;
                        r_prev_omega <= rd_omega;
                    end
                end
            end
            S_LDIFF: begin
                r_v0          <= v0;
                r_neg         <= dv[VW];
                r_mul_a       <= {1'b0, dv_abs[VW-1:0]};
                r_mul_b       <= MB'(r_dl);
                r_blend_phase <= 1'b0;
            end
            S_BDIFF: begin
                r_mul_a       <= bdiff;
                r_mul_b       <= MB'(r_blend);
                r_blend_phase <= 1'b1;
            end
            S_MUL: begin
                r_prod <= r_mul_a * r_mul_b;
            end
            S_DIV: begin
                if (div_stat.done) begin
                    if (r_sel) begin
                        r_o <= lerp_val;
                    end else begin
                        r_a   <= lerp_val;
                        r_sel <= 1'b1;
                    end
                end
            end
            S_SAT: begin
                if (out_load) begin
                    r_out_value <= sat_hi ? VMAX : (sat_lo ? VMIN : res[VW-1:0]);
                    r_out_sat   <= sat_hi || sat_lo;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_blended_value = r_out_value;
    assign o_saturated     = r_out_sat;

    // Checks
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH && r_rd_vld) |-> (r_rd_idx <= r_last))
        else $error("table walk went past the last entry in use");

    a_lerp_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LDIFF) |-> (r_dl < r_dd))
        else $error("interpolation offset not below key span");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_go |-> (!div_stat.busy && (r_prod[2*VW-1:VW] < r_dd)))
        else $error("divider started busy or with an oversized quotient");

endmodule
`default_nettype wire
